### design/fcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared widths, codes and reset values for the failure circuit breaker.
// ----------------------------------------------------------------------------
package fcb_pkg;

    localparam int unsigned CNT_W   = 32;
    localparam int unsigned FAIL_W  = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 1;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [OP_W-1:0]   t_op;

    localparam t_mode MODE_CLOSED = 2'd0;
    localparam t_mode MODE_OPEN   = 2'd1;
    localparam t_mode MODE_HALF   = 2'd2;

    localparam t_op OP_REQUEST   = 2'd0;
    localparam t_op OP_REPORT    = 2'd1;
    localparam t_op OP_RST_BRK   = 2'd2;
    localparam t_op OP_RST_CNT   = 2'd3;

    localparam logic [CIDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT   = 1'd1;

    localparam logic [CFG_W-1:0]  THRESHOLD_RESET = 16'd5;
    localparam logic [CFG_W-1:0]  TIMEOUT_RESET   = 16'd30;
    localparam logic [FAIL_W-1:0] FAIL_MAX        = 16'hFFFF;

endpackage

### design/failure_circuit_breaker_core.sv
// A result is registered in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the input is not stalled; all work is one pass of compare,
// increment and select logic from the input ports into the state registers.
// Input stall is high only while a result waits and the output is stalled.
// Reset (synchronous, active low) closes the breaker, clears every counter,
// and loads the threshold with 5 and the timeout with 30 seconds.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failure_circuit_breaker_core
// Closed/open/half-open circuit breaker with wrapping operation counters.
// ----------------------------------------------------------------------------
module failure_circuit_breaker_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fcb_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [fcb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [fcb_pkg::OP_W-1:0]     i_opcode,
    input  logic [fcb_pkg::CNT_W-1:0]    i_now_sec,
    input  logic                         i_op_failed,
    input  logic                         i_fast_path,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_permitted,
    output logic [fcb_pkg::MODE_W-1:0]   o_breaker_state,
    output logic [fcb_pkg::FAIL_W-1:0]   o_fail_count,
    output logic [fcb_pkg::CNT_W-1:0]    o_total_count,
    output logic [fcb_pkg::CNT_W-1:0]    o_failed_count,
    output logic [fcb_pkg::CNT_W-1:0]    o_fast_count,
    output logic [fcb_pkg::CNT_W-1:0]    o_slow_count,
    output logic [fcb_pkg::CNT_W-1:0]    o_trip_count
);
    import fcb_pkg::*;

    logic [CFG_W-1:0]  r_threshold;
    logic [CFG_W-1:0]  r_timeout;
    t_mode             r_mode,      n_mode;
    logic [FAIL_W-1:0] r_fails,     n_fails;
    logic [CNT_W-1:0]  r_last_fail, n_last_fail;
    logic [CNT_W-1:0]  r_total,     n_total;
    logic [CNT_W-1:0]  r_failed,    n_failed;
    logic [CNT_W-1:0]  r_fast,      n_fast;
    logic [CNT_W-1:0]  r_slow,      n_slow;
    logic [CNT_W-1:0]  r_trips,     n_trips;
    logic              r_permitted, n_permitted;
    logic              r_out_valid;

    logic              w_accept;
    logic [CNT_W-1:0]  w_elapsed;
    logic              w_timed_out;
    logic [FAIL_W-1:0] w_fails_inc;

    // The result register frees up in the same cycle its transaction is taken.
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    assign w_elapsed   = i_now_sec - r_last_fail;
    assign w_timed_out = w_elapsed >= {{(CNT_W-CFG_W){1'b0}}, r_timeout};
    assign w_fails_inc = (r_fails == FAIL_MAX) ? r_fails : r_fails + 1'b1;

    always_comb begin
        n_mode      = r_mode;
        n_fails     = r_fails;
        n_last_fail = r_last_fail;
        n_total     = r_total;
        n_failed    = r_failed;
        n_fast      = r_fast;
        n_slow      = r_slow;
        n_trips     = r_trips;
        n_permitted = 1'b0;
        case (i_opcode)
            OP_REQUEST: begin
                if (r_mode != MODE_OPEN) begin
                    n_permitted = 1'b1;
                end else if (w_timed_out) begin
                    n_permitted = 1'b1;
                    n_mode      = MODE_HALF;
                end
            end
            OP_REPORT: begin
                if (i_op_failed) begin
                    n_fails     = w_fails_inc;
                    n_last_fail = i_now_sec;
                    n_failed    = r_failed + 1'b1;
                    if (w_fails_inc >= r_threshold) begin
                        n_mode  = MODE_OPEN;
                        n_trips = r_trips + 1'b1;
                    end
                end else begin
                    n_fails = '0;
                    n_mode  = MODE_CLOSED;
                end
                n_total = r_total + 1'b1;
                if (i_fast_path) begin
                    n_fast = r_fast + 1'b1;
                end else begin
                    n_slow = r_slow + 1'b1;
                end
            end
            OP_RST_BRK: begin
                n_mode      = MODE_CLOSED;
                n_fails     = '0;
                n_last_fail = '0;
            end
            default: begin
                n_total  = '0;
                n_failed = '0;
                n_fast   = '0;
                n_slow   = '0;
                n_trips  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default:       r_timeout   <= r_timeout;
            endcase
        end
    end

    // Breaker state and counters double as the result fields; they only
    // change on an accepted transaction, so they hold while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_CLOSED;
            r_fails     <= '0;
            r_last_fail <= '0;
            r_total     <= '0;
            r_failed    <= '0;
            r_fast      <= '0;
            r_slow      <= '0;
            r_trips     <= '0;
            r_permitted <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mode      <= n_mode;
                r_fails     <= n_fails;
                r_last_fail <= n_last_fail;
                r_total     <= n_total;
                r_failed    <= n_failed;
                r_fast      <= n_fast;
                r_slow      <= n_slow;
                r_trips     <= n_trips;
                r_permitted <= n_permitted;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_permitted     = r_permitted;
    assign o_breaker_state = r_mode;
    assign o_fail_count    = r_fails;
    assign o_total_count   = r_total;
    assign o_failed_count  = r_failed;
    assign o_fast_count    = r_fast;
    assign o_slow_count    = r_slow;
    assign o_trip_count    = r_trips;

endmodule

### design/fcb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcb_checker
// Port-level checks for the failure circuit breaker, bound to the top level.
// ----------------------------------------------------------------------------
module fcb_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic                         o_permitted,
    input  logic [fcb_pkg::MODE_W-1:0]   o_breaker_state,
    input  logic [fcb_pkg::FAIL_W-1:0]   o_fail_count,
    input  logic [fcb_pkg::CNT_W-1:0]    o_total_count
);
    import fcb_pkg::*;

    // A stalled result transaction stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_breaker_state) && $stable(o_fail_count)
                               && $stable(o_total_count) && $stable(o_permitted))
        else $error("result payload changed while stalled");

    // An admitted request never leaves the breaker open.
    a_permit_not_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_permitted |-> o_breaker_state != MODE_OPEN)
        else $error("request admitted but breaker reported open");

    // The breaker only opens on a failure, so an open breaker has a count.
    a_open_has_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_breaker_state == MODE_OPEN |-> o_fail_count != '0)
        else $error("open breaker with zero failure count");

endmodule

bind failure_circuit_breaker_core fcb_checker u_fcb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_permitted     (o_permitted),
    .o_breaker_state (o_breaker_state),
    .o_fail_count    (o_fail_count),
    .o_total_count   (o_total_count)
);
